// ----- src/btt_pkg.sv -----
package btt_pkg;

	localparam int TURN_BITS = 32;
	localparam int SCALED_BITS = 60;
	localparam int SCALE_TOP = 56;
	localparam int TABLE_DEPTH = 32;

	localparam logic [TURN_BITS-1:0] HALF_TURN = 32'h8000_0000;

	localparam logic [TURN_BITS-1:0] ATAN_TABLE [TABLE_DEPTH] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	typedef struct packed {
		logic valid;
		logic zero;
	} btt_ctl_t;

endpackage

// ----- src/btt_in_if.sv -----
interface btt_in_if #(
	parameter int ANGLE_BITS = 16,
	parameter int COORD_BITS = 16
);
	logic valid;
	logic ready;
	logic [ANGLE_BITS-1:0] heading;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] dest_x;
	logic signed [COORD_BITS-1:0] dest_y;

	modport source (output valid, heading, start_x, start_y, dest_x, dest_y, input ready);
	modport sink (input valid, heading, start_x, start_y, dest_x, dest_y, output ready);
endinterface

// ----- src/btt_out_if.sv -----
interface btt_out_if #(
	parameter int ANGLE_BITS = 16
);
	logic valid;
	logic ready;
	logic [ANGLE_BITS-1:0] bearing;
	logic signed [ANGLE_BITS-1:0] turn;

	modport source (output valid, bearing, turn, input ready);
	modport sink (input valid, bearing, turn, output ready);
endinterface

// ----- src/bearing_and_turn_to_target.sv -----
// channel  dir  handshake      payload
// req      in   valid/ready    heading, start_x, start_y, dest_x, dest_y
// rsp      out  valid/ready    bearing, turn
//
// one request per cycle while rsp is not stalled
// each result passes the prep register, one cell per CORDIC stage and the output register
// arst_n clears only the valid bits of the prep register, the cells and the output register
// a stalled rsp freezes the whole chain and drops req.ready

module bearing_and_turn_to_target #(
	parameter int ANGLE_BITS = 16,
	parameter int COORD_BITS = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic clk,
	input  logic arst_n,
	btt_in_if.sink req,
	btt_out_if.source rsp
);
	import btt_pkg::*;

	localparam int XW = SCALED_BITS;

	logic en;
	logic signed [XW-1:0] cx [CORDIC_STAGES+1];
	logic signed [XW-1:0] cy [CORDIC_STAGES+1];
	logic [TURN_BITS-1:0] cz [CORDIC_STAGES+1];
	logic [ANGLE_BITS-1:0] ch [CORDIC_STAGES+1];
	btt_ctl_t cc [CORDIC_STAGES+1];

	assign en = !rsp.valid || rsp.ready;
	assign req.ready = en;

	btt_prep #(
		.ANGLE_BITS(ANGLE_BITS),
		.COORD_BITS(COORD_BITS),
		.XW(XW)
	) u_prep (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.take(req.valid),
		.heading(req.heading),
		.start_x(req.start_x),
		.start_y(req.start_y),
		.dest_x(req.dest_x),
		.dest_y(req.dest_y),
		.next_x(cx[0]),
		.next_y(cy[0]),
		.next_z(cz[0]),
		.next_heading(ch[0]),
		.next_ctl(cc[0])
	);

	generate
		for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
			btt_cell #(
				.ANGLE_BITS(ANGLE_BITS),
				.XW(XW),
				.STAGE(i)
			) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.en(en),
				.prev_x(cx[i]),
				.prev_y(cy[i]),
				.prev_z(cz[i]),
				.prev_heading(ch[i]),
				.prev_ctl(cc[i]),
				.next_x(cx[i+1]),
				.next_y(cy[i+1]),
				.next_z(cz[i+1]),
				.next_heading(ch[i+1]),
				.next_ctl(cc[i+1])
			);
		end
	endgenerate

	btt_post #(
		.ANGLE_BITS(ANGLE_BITS)
	) u_post (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.prev_z(cz[CORDIC_STAGES]),
		.prev_heading(ch[CORDIC_STAGES]),
		.prev_ctl(cc[CORDIC_STAGES]),
		.valid(rsp.valid),
		.bearing(rsp.bearing),
		.turn(rsp.turn)
	);

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |-> !req.ready)
		else $error("request taken while result stalled");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> cc[0].valid)
		else $error("accepted request missing from first stage");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |=> $stable(cc[CORDIC_STAGES]) && $stable(cz[CORDIC_STAGES]))
		else $error("cell chain moved during stall");

	a_zero_bearing: assert property (@(posedge clk) disable iff (!arst_n)
		en && cc[CORDIC_STAGES].valid && cc[CORDIC_STAGES].zero |=> rsp.bearing == '0)
		else $error("zero-length vector gave nonzero bearing");
endmodule

// ----- src/btt_prep.sv -----
module btt_prep #(
	parameter int ANGLE_BITS = 16,
	parameter int COORD_BITS = 16,
	parameter int XW = 60
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic take,
	input  logic [ANGLE_BITS-1:0] heading,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] dest_x,
	input  logic signed [COORD_BITS-1:0] dest_y,
	output logic signed [XW-1:0] next_x,
	output logic signed [XW-1:0] next_y,
	output logic [btt_pkg::TURN_BITS-1:0] next_z,
	output logic [ANGLE_BITS-1:0] next_heading,
	output btt_pkg::btt_ctl_t next_ctl
);
	import btt_pkg::*;

	localparam int SCALE_SHIFT = SCALE_TOP - COORD_BITS;

	logic signed [COORD_BITS:0] dx;
	logic signed [COORD_BITS:0] dy;
	logic signed [XW-1:0] xw;
	logic signed [XW-1:0] yw;
	logic signed [XW-1:0] x_q;
	logic signed [XW-1:0] y_q;
	logic [TURN_BITS-1:0] z_q;
	logic [ANGLE_BITS-1:0] heading_q;
	logic valid_q;
	logic zero_q;

	assign dx = $signed({dest_x[COORD_BITS-1], dest_x}) - $signed({start_x[COORD_BITS-1], start_x});
	assign dy = $signed({dest_y[COORD_BITS-1], dest_y}) - $signed({start_y[COORD_BITS-1], start_y});
	assign xw = XW'(dx) <<< SCALE_SHIFT;
	assign yw = XW'(dy) <<< SCALE_SHIFT;

	// left half plane turned by a half turn
	always_ff @(posedge clk) begin
		if (en) begin
			if (dx[COORD_BITS]) begin
				x_q <= -xw;
				y_q <= -yw;
				z_q <= HALF_TURN;
			end else begin
				x_q <= xw;
				y_q <= yw;
				z_q <= '0;
			end
			heading_q <= heading;
			zero_q <= (dx == '0) && (dy == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= take;
		end
	end

	assign next_x = x_q;
	assign next_y = y_q;
	assign next_z = z_q;
	assign next_heading = heading_q;
	assign next_ctl = '{valid: valid_q, zero: zero_q};
endmodule

// ----- src/btt_cell.sv -----
module btt_cell #(
	parameter int ANGLE_BITS = 16,
	parameter int XW = 60,
	parameter int STAGE = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic signed [XW-1:0] prev_x,
	input  logic signed [XW-1:0] prev_y,
	input  logic [btt_pkg::TURN_BITS-1:0] prev_z,
	input  logic [ANGLE_BITS-1:0] prev_heading,
	input  btt_pkg::btt_ctl_t prev_ctl,
	output logic signed [XW-1:0] next_x,
	output logic signed [XW-1:0] next_y,
	output logic [btt_pkg::TURN_BITS-1:0] next_z,
	output logic [ANGLE_BITS-1:0] next_heading,
	output btt_pkg::btt_ctl_t next_ctl
);
	import btt_pkg::*;

	localparam int K = STAGE % TABLE_DEPTH;
	localparam logic [TURN_BITS-1:0] STEP_ANGLE = ATAN_TABLE[K];

	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;
	logic signed [XW-1:0] x_q;
	logic signed [XW-1:0] y_q;
	logic [TURN_BITS-1:0] z_q;
	logic [ANGLE_BITS-1:0] heading_q;
	logic valid_q;
	logic zero_q;

	assign xs = prev_x >>> K;
	assign ys = prev_y >>> K;

	// clockwise when y is non-negative
	always_ff @(posedge clk) begin
		if (en) begin
			if (!prev_y[XW-1]) begin
				x_q <= prev_x + ys;
				y_q <= prev_y - xs;
				z_q <= prev_z + STEP_ANGLE;
			end else begin
				x_q <= prev_x - ys;
				y_q <= prev_y + xs;
				z_q <= prev_z - STEP_ANGLE;
			end
			heading_q <= prev_heading;
			zero_q <= prev_ctl.zero;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= prev_ctl.valid;
		end
	end

	assign next_x = x_q;
	assign next_y = y_q;
	assign next_z = z_q;
	assign next_heading = heading_q;
	assign next_ctl = '{valid: valid_q, zero: zero_q};
endmodule

// ----- src/btt_post.sv -----
module btt_post #(
	parameter int ANGLE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic [btt_pkg::TURN_BITS-1:0] prev_z,
	input  logic [ANGLE_BITS-1:0] prev_heading,
	input  btt_pkg::btt_ctl_t prev_ctl,
	output logic valid,
	output logic [ANGLE_BITS-1:0] bearing,
	output logic signed [ANGLE_BITS-1:0] turn
);
	import btt_pkg::*;

	localparam int SHIFT = TURN_BITS - ANGLE_BITS;

	logic [ANGLE_BITS-1:0] rounded;
	logic [ANGLE_BITS-1:0] angle;
	logic [ANGLE_BITS-1:0] bearing_q;
	logic [ANGLE_BITS-1:0] turn_q;
	logic valid_q;

	generate
		if (SHIFT > 0) begin : g_round
			logic [TURN_BITS-1:0] sum;
			assign sum = prev_z + (TURN_BITS'(1) << (SHIFT - 1));
			assign rounded = sum[TURN_BITS-1:SHIFT];
		end else begin : g_exact
			assign rounded = prev_z[ANGLE_BITS-1:0];
		end
	endgenerate

	assign angle = prev_ctl.zero ? '0 : rounded;

	always_ff @(posedge clk) begin
		if (en) begin
			bearing_q <= angle;
			turn_q <= angle - prev_heading;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= prev_ctl.valid;
		end
	end

	assign valid = valid_q;
	assign bearing = bearing_q;
	assign turn = $signed(turn_q);
endmodule

// ----- tb/sv/bearing_and_turn_to_target_test.sv -----
module bearing_and_turn_to_target_test;

	localparam int ANGLE_BITS = 16;
	localparam int COORD_BITS = 16;
	localparam int CORDIC_STAGES = 16;
	localparam int TURN_BITS = 32;
	localparam int SCALE_SHIFT = 56 - COORD_BITS;
	localparam int ROUND_SHIFT = TURN_BITS - ANGLE_BITS;
	localparam logic [TURN_BITS-1:0] HALF_TURN = 32'h8000_0000;
	localparam int RANDOM_MOVES = 1750;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int SETTLE_CYCLES = CORDIC_STAGES + 8;
	localparam longint TIMEOUT_CYCLES = 400000;

	localparam logic [TURN_BITS-1:0] ATAN_TURN [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	typedef struct {
		logic [ANGLE_BITS-1:0] heading;
		logic signed [COORD_BITS-1:0] start_x;
		logic signed [COORD_BITS-1:0] start_y;
		logic signed [COORD_BITS-1:0] dest_x;
		logic signed [COORD_BITS-1:0] dest_y;
	} move_t;

	typedef enum int {ALWAYS_READY, COIN_FLIP, MOSTLY_READY, EVERY_THIRD} stall_pattern_t;

	class bearing_scoreboard;
		typedef struct {
			logic [ANGLE_BITS-1:0] bearing;
			logic signed [ANGLE_BITS-1:0] turn;
		} steer_t;

		steer_t expected_steers[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function int waiting();
			return expected_steers.size();
		endfunction

		function logic [ANGLE_BITS-1:0] bearing_of(longint dx, longint dy);
			longint x, y, nx, ny;
			logic [TURN_BITS-1:0] z;
			logic [TURN_BITS:0] rounded;
			int k;
			if (dx == 0 && dy == 0)
				return '0;
			x = dx <<< SCALE_SHIFT;
			y = dy <<< SCALE_SHIFT;
			z = '0;
			// left half plane: rotate by a half turn first
			if (x < 0) begin
				x = -x;
				y = -y;
				z = HALF_TURN;
			end
			for (int i = 0; i < CORDIC_STAGES; i++) begin
				k = i % 32;
				if (y >= 0) begin
					nx = x + (y >>> k);
					ny = y - (x >>> k);
					z = z + ATAN_TURN[k];
				end else begin
					nx = x - (y >>> k);
					ny = y + (x >>> k);
					z = z - ATAN_TURN[k];
				end
				x = nx;
				y = ny;
			end
			rounded = ({1'b0, z} + (33'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
			return rounded[ANGLE_BITS-1:0];
		endfunction

		function void note_request(move_t m);
			steer_t s;
			longint dx, dy;
			dx = longint'(m.dest_x) - longint'(m.start_x);
			dy = longint'(m.dest_y) - longint'(m.start_y);
			s.bearing = bearing_of(dx, dy);
			s.turn = s.bearing - m.heading;
			expected_steers.push_back(s);
		endfunction

		function void check_result(logic [ANGLE_BITS-1:0] bearing,
				logic signed [ANGLE_BITS-1:0] turn);
			steer_t s;
			if (expected_steers.size() == 0) begin
				$error("result with no request pending: bearing %0d, turn %0d", bearing, turn);
				errors++;
				return;
			end
			s = expected_steers.pop_front();
			if (bearing !== s.bearing) begin
				$error("bearing mismatch: expected %0d, actual %0d", s.bearing, bearing);
				errors++;
			end
			if (turn !== s.turn) begin
				$error("turn mismatch: expected %0d, actual %0d", s.turn, turn);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic hold_off_req;
	int moves_sent;
	bearing_scoreboard sb;

	btt_in_if #(.ANGLE_BITS(ANGLE_BITS), .COORD_BITS(COORD_BITS)) req();
	btt_out_if #(.ANGLE_BITS(ANGLE_BITS)) rsp();

	bearing_and_turn_to_target #(
		.ANGLE_BITS(ANGLE_BITS),
		.COORD_BITS(COORD_BITS),
		.CORDIC_STAGES(CORDIC_STAGES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_CYCLES * 20);
		$display("Test completed with failures");
		$finish;
	end

	always @(posedge clk) begin
		if (req.valid === 1'b1 && req.ready === 1'b1)
			sb.note_request('{req.heading, req.start_x, req.start_y, req.dest_x, req.dest_y});
		if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
			sb.check_result(rsp.bearing, rsp.turn);
	end

	// receiver stall patterns, plus a long hold-off on request
	initial begin
		int hold_left, pattern_left, phase;
		stall_pattern_t pattern;
		rsp.ready = 1'b0;
		hold_left = 0;
		pattern_left = 0;
		phase = 0;
		pattern = ALWAYS_READY;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (pattern_left == 0) begin
				pattern = stall_pattern_t'($urandom_range(0, 3));
				pattern_left = $urandom_range(20, 200);
			end
			pattern_left--;
			phase++;
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else begin
				case (pattern)
					ALWAYS_READY: rsp.ready <= 1'b1;
					COIN_FLIP: rsp.ready <= 1'($urandom_range(0, 1));
					MOSTLY_READY: rsp.ready <= ($urandom_range(0, 9) != 0);
					EVERY_THIRD: rsp.ready <= (phase % 3 == 0);
					default: rsp.ready <= 1'b1;
				endcase
			end
		end
	end

	task automatic send_move(input move_t m);
		@(negedge clk);
		req.heading <= m.heading;
		req.start_x <= m.start_x;
		req.start_y <= m.start_y;
		req.dest_x <= m.dest_x;
		req.dest_y <= m.dest_y;
		req.valid <= 1'b1;
		do
			@(posedge clk);
		while (req.ready !== 1'b1);
		moves_sent++;
	endtask

	task automatic pause_sender(input int cycles);
		if (cycles > 0) begin
			@(negedge clk);
			req.valid <= 1'b0;
			repeat (cycles - 1) @(negedge clk);
		end
	endtask

	task automatic wait_all_results();
		@(negedge clk);
		req.valid <= 1'b0;
		while (sb.waiting() != 0)
			@(negedge clk);
	endtask

	function automatic move_t make_move(int heading, int sx, int sy, int tx, int ty);
		move_t m;
		m.heading = heading[ANGLE_BITS-1:0];
		m.start_x = sx[COORD_BITS-1:0];
		m.start_y = sy[COORD_BITS-1:0];
		m.dest_x = tx[COORD_BITS-1:0];
		m.dest_y = ty[COORD_BITS-1:0];
		return m;
	endfunction

	function automatic int corner_coord();
		case ($urandom_range(0, 4))
			0: return -32768;
			1: return -1;
			2: return 0;
			3: return 1;
			default: return 32767;
		endcase
	endfunction

	function automatic move_t random_move();
		move_t m;
		int sx, sy, d;
		m.heading = ANGLE_BITS'($urandom());
		if ($urandom_range(0, 7) == 0)
			m.heading = $urandom_range(0, 1) ? '1 : '0;
		m.start_x = COORD_BITS'($urandom());
		m.start_y = COORD_BITS'($urandom());
		m.dest_x = COORD_BITS'($urandom());
		m.dest_y = COORD_BITS'($urandom());
		sx = int'(m.start_x);
		sy = int'(m.start_y);
		case ($urandom_range(0, 9))
			4, 5: begin
				// short vector near the start point
				m.dest_x = COORD_BITS'(sx + $signed($urandom_range(0, 16)) - 8);
				m.dest_y = COORD_BITS'(sy + $signed($urandom_range(0, 16)) - 8);
			end
			6: begin
				if ($urandom_range(0, 1))
					m.dest_x = m.start_x;
				else
					m.dest_y = m.start_y;
			end
			7: begin
				m.dest_x = m.start_x;
				m.dest_y = m.start_y;
			end
			8: begin
				m.start_x = COORD_BITS'(corner_coord());
				m.start_y = COORD_BITS'(corner_coord());
				m.dest_x = COORD_BITS'(corner_coord());
				m.dest_y = COORD_BITS'(corner_coord());
			end
			9: begin
				// diagonal, equal magnitudes
				d = $urandom_range(1, 16000);
				m.dest_x = COORD_BITS'(sx + ($urandom_range(0, 1) ? d : -d));
				m.dest_y = COORD_BITS'(sy + ($urandom_range(0, 1) ? d : -d));
			end
			default: ;
		endcase
		return m;
	endfunction

	initial begin
		move_t directed[$];
		int random_sent, burst, gap;
		bit held, drained;
		sb = new();
		moves_sent = 0;
		hold_off_req = 1'b0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.heading = '0;
		req.start_x = '0;
		req.start_y = '0;
		req.dest_x = '0;
		req.dest_y = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// zero length, axes, half planes, opposite heading, extremes
		directed.push_back(make_move(16'h1234, 100, -200, 100, -200));
		directed.push_back(make_move(16'hFFFF, -32768, 32767, -32768, 32767));
		directed.push_back(make_move(16'h0000, 0, 0, 1000, 0));
		directed.push_back(make_move(16'h8000, 0, 0, 1000, 0));
		directed.push_back(make_move(16'h4000, 0, 0, 0, 500));
		directed.push_back(make_move(16'h0000, 0, 0, 0, -500));
		directed.push_back(make_move(16'hC000, 10, 10, -5000, 10));
		directed.push_back(make_move(16'h0000, 32767, 0, -32768, 0));
		directed.push_back(make_move(16'h8000, -32768, 0, 32767, 0));
		directed.push_back(make_move(16'h2000, 0, 32767, 0, -32768));
		directed.push_back(make_move(16'h6000, 0, -32768, 0, 32767));
		directed.push_back(make_move(16'h7FFF, -32768, -32768, 32767, 32767));
		directed.push_back(make_move(16'hFFFF, 32767, 32767, -32768, -32768));
		directed.push_back(make_move(16'h0001, 0, 0, -300, 400));
		directed.push_back(make_move(16'h7FFF, 0, 0, -300, -400));
		directed.push_back(make_move(16'h8001, 0, 0, 300, -400));
		directed.push_back(make_move(16'h0000, 0, 0, 1, 1));
		directed.push_back(make_move(16'h0000, 0, 0, -1, 0));
		directed.push_back(make_move(16'h0000, 0, 0, 0, -1));
		directed.push_back(make_move(16'h0000, 0, 0, 1, 32767));
		directed.push_back(make_move(16'h0000, 0, 0, -32768, -1));
		directed.push_back(make_move(16'h0000, 0, 0, -32768, 1));
		directed.push_back(make_move(16'hC000, 5, 5, 5, -32768));
		foreach (directed[i])
			send_move(directed[i]);
		wait_all_results();

		random_sent = 0;
		held = 1'b0;
		drained = 1'b0;
		while (random_sent < RANDOM_MOVES) begin
			if (!held && random_sent >= 500) begin
				// long receiver hold-off while requests keep coming
				hold_off_req = 1'b1;
				repeat (80) begin
					send_move(random_move());
					random_sent++;
				end
				held = 1'b1;
			end
			if (!drained && random_sent >= 1000) begin
				wait_all_results();
				drained = 1'b1;
			end
			burst = $urandom_range(1, 24);
			repeat (burst) begin
				send_move(random_move());
				random_sent++;
			end
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
			pause_sender(gap);
			if ($urandom_range(0, 29) == 0)
				wait_all_results();
		end

		wait_all_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (sb.errors == 0 && sb.waiting() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
